// File: hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared constants, types and helpers of the deadline-ordered task queue.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int DATA_W      = 32;
  localparam int ACTIVE_W    = 5;

  localparam logic [1:0] OP_RELEASE  = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;

  localparam logic [1:0] KIND_ON_TIME = 2'd0;
  localparam logic [1:0] KIND_OVERDUE = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [DATA_W-1:0] iteration;
    logic [DATA_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic remove_head;
    logic remove_match;
    logic insert;
  } cell_ctl_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// File: hdl/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One slot of the sorted queue: holds an entry, shifts toward the head on a
// removal and toward the tail on an insertion.
// ----------------------------------------------------------------------------
module edf_cell (
  input  logic              clk,
  input  edf_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              hit_in,
  input  logic              gt_in,
  input  edf_pkg::entry_t   req_entry,
  input  edf_pkg::entry_t   left_entry,
  input  edf_pkg::entry_t   right_entry,
  output edf_pkg::entry_t   entry,
  output logic              hit_out,
  output logic              gt_out,
  output logic              match
);
  import edf_pkg::*;

  assign match   = occupied && (entry.task_id == req_entry.task_id) &&
                   (entry.iteration == req_entry.iteration);
  assign hit_out = hit_in | match;
  assign gt_out  = !occupied || (entry.deadline > req_entry.deadline);

  always_ff @(posedge clk) begin
    if (ctl.remove_head || (ctl.remove_match && hit_out)) begin
      entry <= right_entry;
    end else if (ctl.insert) begin
      if (gt_in) begin
        entry <= left_entry;
      end else if (gt_out) begin
        entry <= req_entry;
      end
    end
  end

endmodule

// File: hdl/edf_deadline_task_queue.sv
// ----------------------------------------------------------------------------
// edf_deadline_task_queue
// Earliest-deadline-first task queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Sequence: a complete request first matches in S_COMPLETE, every request then
// sweeps expired entries from the head in S_SWEEP, inserts a release in
// S_RELEASE and reports in S_SUMMARY; a new request is taken only in S_IDLE.
// The head cell retires one expired entry per cycle while the output is not
// stalled.
// Reset: queue empty, counters zero; cell contents are not reset.
module edf_deadline_task_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [edf_pkg::ID_W-1:0]     task_id,
  input  logic [edf_pkg::DATA_W-1:0]   iteration,
  input  logic [edf_pkg::DATA_W-1:0]   deadline,
  input  logic [edf_pkg::DATA_W-1:0]   now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [edf_pkg::ID_W-1:0]     task_id_res,
  output logic [edf_pkg::DATA_W-1:0]   iteration_res,
  output logic [edf_pkg::DATA_W-1:0]   deadline_res,
  output logic [1:0]                   status,
  output logic                         head_valid,
  output logic [edf_pkg::ACTIVE_W-1:0] active_count,
  output logic [edf_pkg::DATA_W-1:0]   completed_count,
  output logic [edf_pkg::DATA_W-1:0]   overdue_count,
  output logic                         last
);
  import edf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_COMPLETE = 5'b00010,
    S_SWEEP    = 5'b00100,
    S_RELEASE  = 5'b01000,
    S_SUMMARY  = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_dec;
  logic [DATA_W-1:0]  on_time_total;
  logic [DATA_W-1:0]  overdue_total;
  logic [DATA_W-1:0]  on_time_inc;
  logic [DATA_W-1:0]  overdue_inc;
  logic [1:0]         evt_status;
  logic [1:0]         op_q;
  logic [DATA_W-1:0]  now_q;
  entry_t             req_q;

  entry_t             cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH:0]   hit_chain;
  logic [QUEUE_DEPTH:0]   gt_chain;
  cell_ctl_t          ctl;
  entry_t             hit_entry;
  logic               any_hit;
  logic               head_due;
  logic               hit_late;
  logic               out_free;
  logic               out_load;

  assign hit_chain[0] = 1'b0;
  assign gt_chain[0]  = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;

    assign occupied[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_e = req_q;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end

    edf_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occupied[i]),
      .hit_in      (hit_chain[i]),
      .gt_in       (gt_chain[i]),
      .req_entry   (req_q),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .hit_out     (hit_chain[i+1]),
      .gt_out      (gt_chain[i+1]),
      .match       (match[i])
    );
  end

  // first matching cell from the head
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (match[i] && !hit_chain[i]) begin
        hit_entry = hit_entry | cell_q[i];
      end
    end
  end

  assign any_hit     = hit_chain[QUEUE_DEPTH];
  assign hit_late    = now_q > hit_entry.deadline;
  assign head_due    = occupied[0] && (now_q >= cell_q[0].deadline);
  assign out_free    = !out_valid || out_ready;
  assign out_load    = out_free && (((state == S_COMPLETE) && any_hit) ||
                                    ((state == S_SWEEP) && head_due) ||
                                    (state == S_SUMMARY));
  assign count_dec   = count - 1'b1;
  assign on_time_inc = sat_inc(on_time_total);
  assign overdue_inc = sat_inc(overdue_total);
  assign in_ready    = (state == S_IDLE);

  always_comb begin
    ctl.remove_match = (state == S_COMPLETE) && any_hit && out_free;
    ctl.remove_head  = (state == S_SWEEP) && head_due && out_free;
    ctl.insert       = (state == S_RELEASE) && (op_q == OP_RELEASE) &&
                       (count != CNT_W'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      on_time_total <= '0;
      overdue_total <= '0;
      out_valid     <= 1'b0;
      evt_status    <= STATUS_OK;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= operation;
            now_q      <= now;
            req_q      <= '{task_id: task_id, iteration: iteration, deadline: deadline};
            evt_status <= STATUS_OK;
            state      <= (operation == OP_COMPLETE) ? S_COMPLETE : S_SWEEP;
          end
        end
        S_COMPLETE: begin
          if (!any_hit) begin
            evt_status <= STATUS_NOT_FOUND;
            state      <= S_SWEEP;
          end else if (out_free) begin
            count         <= count_dec;
            kind          <= hit_late ? KIND_OVERDUE : KIND_ON_TIME;
            task_id_res   <= hit_entry.task_id;
            iteration_res <= hit_entry.iteration;
            deadline_res  <= hit_entry.deadline;
            status        <= STATUS_OK;
            head_valid    <= (count_dec != '0);
            active_count  <= ACTIVE_W'(count_dec);
            last          <= 1'b0;
            if (hit_late) begin
              overdue_total   <= overdue_inc;
              completed_count <= on_time_total;
              overdue_count   <= overdue_inc;
            end else begin
              on_time_total   <= on_time_inc;
              completed_count <= on_time_inc;
              overdue_count   <= overdue_total;
            end
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (!head_due) begin
            state <= S_RELEASE;
          end else if (out_free) begin
            count           <= count_dec;
            overdue_total   <= overdue_inc;
            kind            <= KIND_OVERDUE;
            task_id_res     <= cell_q[0].task_id;
            iteration_res   <= cell_q[0].iteration;
            deadline_res    <= cell_q[0].deadline;
            status          <= STATUS_OK;
            head_valid      <= (count_dec != '0);
            active_count    <= ACTIVE_W'(count_dec);
            completed_count <= on_time_total;
            overdue_count   <= overdue_inc;
            last            <= 1'b0;
          end
        end
        S_RELEASE: begin
          if (op_q == OP_RELEASE) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              evt_status <= STATUS_FULL;
            end else begin
              count <= count + 1'b1;
            end
          end
          state <= S_SUMMARY;
        end
        S_SUMMARY: begin
          if (out_free) begin
            kind            <= KIND_SUMMARY;
            task_id_res     <= occupied[0] ? cell_q[0].task_id : '0;
            iteration_res   <= occupied[0] ? cell_q[0].iteration : '0;
            deadline_res    <= occupied[0] ? cell_q[0].deadline : '0;
            status          <= evt_status;
            head_valid      <= occupied[0];
            active_count    <= ACTIVE_W'(count);
            completed_count <= on_time_total;
            overdue_count   <= overdue_total;
            last            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_last_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_SUMMARY)))
    else $error("last flag disagrees with summary kind");

  for (genvar i = 0; i < QUEUE_DEPTH - 1; i++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      occupied[i+1] |-> (cell_q[i].deadline <= cell_q[i+1].deadline))
      else $error("queue out of deadline order");
  end

endmodule
